### rtl/drp_pkg.sv
// Shared types and constants for the descriptor projection core
`timescale 1ns / 1ps
`default_nettype none
package drp_pkg;

  localparam int PROJ_SLOTS = 4;
  localparam int MAX_ROWS  = 1024;
  localparam int DESC_COLS = 128;

  localparam int PROJ_W = $clog2(PROJ_SLOTS);
  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int COL_W  = $clog2(DESC_COLS);
  localparam int WADDR_W = PROJ_W + ROW_W;
  localparam int AADDR_W = PROJ_W + COL_W;
  localparam int ACC_W   = 56;
  localparam int PROD_W  = 48;
  localparam int RCNT_W  = 11;
  localparam int HIDX_W  = 9;
  localparam int QFIFO_DEPTH = 4;
  localparam int QPTR_W = $clog2(QFIFO_DEPTH);
  localparam int DIV_CNT_W = $clog2(ACC_W + 1);

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_ELEM  = 2'd2,
    CMD_READ  = 2'd3
  } cmd_t;

  localparam logic CFG_NPROJ = 1'b0;
  localparam logic CFG_NCOLS = 1'b1;

  // Work item handed from front to back
  typedef struct packed {
    cmd_t                      cmd;
    logic [PROJ_W-1:0]         proj;
    logic [ROW_W-1:0]          row;
    logic [COL_W-1:0]          col;
    logic                      drop;
    logic [2:0]                nproj;
    logic signed [31:0]        value;
    logic [RCNT_W-1:0]         rows;
    logic [HIDX_W-1:0]         hidx;
    logic                      oor;
  } work_t;

endpackage
`default_nettype wire

### rtl/descriptor_random_projection_core.sv
// Top level of the descriptor random projection core
//
//  channel  | handshake          | beat contents
//  in_      | start / busy       | cmd, indices, weight, sample, row count, hash index
//  out_     | out_valid (strobe) | entry_index, hash_value, out_of_range
//  cfg_     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// The front takes one beat at a time; a read also splits the hash index into
// projection and column by repeated subtraction. A weight load retires in the
// idle state, an in-range element steps through weight read, multiply and accumulate
// for each projection in use, and a read runs the serial divider before its strobe.
// After reset, and on a clear, the back end zeroes the 512 accumulators, one a cycle.
// The queue lets the front take beats while the back works; results cannot stall.
`timescale 1ns / 1ps
`default_nettype none
module descriptor_random_projection_core import drp_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [1:0]        in_cmd,
  input  wire logic [1:0]        in_proj_index,
  input  wire logic [9:0]        in_row_index,
  input  wire logic [6:0]        in_col_index,
  input  wire logic signed [15:0] in_weight,
  input  wire logic signed [31:0] in_sample_value,
  input  wire logic [10:0]       in_row_count,
  input  wire logic [8:0]        in_hash_index,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic              cfg_index,
  input  wire logic [7:0]        cfg_data,
  output logic                   out_valid,
  output logic [8:0]             out_entry_index,
  output logic signed [31:0]     out_hash_value,
  output logic                   out_out_of_range
);

  logic  q_full, q_push, q_pop, q_empty, back_idle, front_busy;
  work_t q_in, q_out;

  // hold off new beats while the front is busy or the queue is full
  assign busy = front_busy || (!back_idle && q_full);

  drp_front u_front (
    .clk, .rst_n, .start(start && !busy), .busy(front_busy),
    .in_cmd, .in_proj_index, .in_row_index, .in_col_index, .in_weight,
    .in_sample_value, .in_row_count, .in_hash_index,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .q_full, .q_push, .q_data(q_in)
  );

  drp_queue u_queue (
    .clk, .rst_n, .push(q_push), .push_data(q_in), .full(q_full),
    .pop(q_pop), .empty(q_empty), .pop_data(q_out)
  );

  drp_back u_back (
    .clk, .rst_n, .q_empty, .q_data(q_out), .q_pop, .idle(back_idle),
    .out_valid, .out_entry_index, .out_hash_value, .out_out_of_range
  );

endmodule
`default_nettype wire

### rtl/drp_front.sv
// Front end: accepts commands, resolves registers, works out read addresses
`timescale 1ns / 1ps
`default_nettype none
module drp_front import drp_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [1:0]        in_cmd,
  input  wire logic [1:0]        in_proj_index,
  input  wire logic [9:0]        in_row_index,
  input  wire logic [6:0]        in_col_index,
  input  wire logic signed [15:0] in_weight,
  input  wire logic signed [31:0] in_sample_value,
  input  wire logic [10:0]       in_row_count,
  input  wire logic [8:0]        in_hash_index,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic              cfg_index,
  input  wire logic [7:0]        cfg_data,
  input  wire logic              q_full,
  output logic                   q_push,
  output work_t                  q_data
);

  logic [2:0] nproj_r;
  logic [7:0] ncols_r;
  logic [2:0] np_eff;
  logic [8:0] nc_eff;
  logic       busy_r, busy_nxt;
  work_t      hold_r;
  logic [8:0] rem_r, rem_nxt;
  logic [PROJ_W:0] pq_r, pq_nxt;
  logic       accept;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nproj_r <= 3'd4;
      ncols_r <= 8'd128;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_NPROJ) nproj_r <= cfg_data[2:0];
      else ncols_r <= cfg_data;
    end
  end

  assign np_eff = (nproj_r == 3'd0) ? 3'd1 :
                  (nproj_r > 3'(PROJ_SLOTS)) ? 3'(PROJ_SLOTS) : nproj_r;
  assign nc_eff = (ncols_r == 8'd0) ? 9'd1 :
                  ({1'b0, ncols_r} > 9'(DESC_COLS)) ? 9'(DESC_COLS) : {1'b0, ncols_r};

  assign busy   = busy_r;
  assign accept = start && !busy_r;

  // a read splits hash_index into projection and column by repeated subtract
  always_comb begin
    busy_nxt = busy_r;
    rem_nxt  = rem_r;
    pq_nxt   = pq_r;
    q_push   = 1'b0;
    q_data   = hold_r;
    if (accept) begin
      busy_nxt = 1'b1;
      rem_nxt  = in_hash_index;
      pq_nxt   = '0;
    end else if (busy_r) begin
      if (hold_r.cmd == CMD_READ && rem_r >= nc_eff && !hold_r.oor) begin
        rem_nxt = rem_r - nc_eff;
        pq_nxt  = pq_r + 1'b1;
      end else if (!q_full) begin
        q_push   = 1'b1;
        busy_nxt = 1'b0;
        if (hold_r.cmd == CMD_READ) begin
          q_data.proj = pq_r[PROJ_W-1:0];
          q_data.col  = rem_r[COL_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    pq_r  <= pq_nxt;
    if (accept) begin
      hold_r.cmd   <= cmd_t'(in_cmd);
      hold_r.proj  <= in_proj_index;
      hold_r.row   <= in_row_index;
      hold_r.col   <= in_col_index;
      hold_r.drop  <= ({2'b0, in_col_index} >= nc_eff);
      hold_r.nproj <= np_eff;
      hold_r.value <= (in_cmd == CMD_LOAD) ? 32'(in_weight) : in_sample_value;
      hold_r.rows  <= in_row_count;
      hold_r.hidx  <= in_hash_index;
      hold_r.oor   <= (12'(in_hash_index) >= 12'(np_eff) * 12'(nc_eff));
    end
  end

endmodule
`default_nettype wire

### rtl/drp_queue.sv
// Short work queue between front and back
`timescale 1ns / 1ps
`default_nettype none
module drp_queue import drp_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire work_t push_data,
  output logic       full,
  input  wire logic  pop,
  output logic       empty,
  output work_t      pop_data
);

  work_t          mem_r [QFIFO_DEPTH];
  logic [QPTR_W-1:0] wp_r, rp_r;
  logic [QPTR_W:0]   cnt_r;

  assign full     = (cnt_r == (QPTR_W+1)'(QFIFO_DEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push && !full) mem_r[wp_r] <= push_data;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push && !full) wp_r <= wp_r + 1'b1;
      if (pop && !empty) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (QPTR_W+1)'(push && !full) - (QPTR_W+1)'(pop && !empty);
    end
  end

endmodule
`default_nettype wire

### rtl/drp_back.sv
// Back end: weight store, accumulator store, MAC sequencer and read divider
`timescale 1ns / 1ps
`default_nettype none
module drp_back import drp_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_empty,
  input  wire work_t             q_data,
  output logic                   q_pop,
  output logic                   idle,
  output logic                   out_valid,
  output logic [8:0]             out_entry_index,
  output logic signed [31:0]     out_hash_value,
  output logic                   out_out_of_range
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_CLEAR = 8'b00000010,
    S_RDW   = 8'b00000100,
    S_MUL   = 8'b00001000,
    S_ADD   = 8'b00010000,
    S_RDA   = 8'b00100000,
    S_DIV   = 8'b01000000,
    S_FIN   = 8'b10000000
  } state_t;

  state_t state_r, state_nxt;
  work_t  w_r;

  logic signed [15:0]      wmem [PROJ_SLOTS*MAX_ROWS];
  logic signed [ACC_W-1:0] amem [PROJ_SLOTS*DESC_COLS];
  logic signed [15:0]      wrd_r;
  logic signed [ACC_W-1:0] ard_r;
  logic [AADDR_W-1:0]      clr_r;
  logic [PROJ_W:0]         p_r;
  logic signed [PROD_W-1:0] prod_r;
  logic                    rd_go_r;

  // divider state
  logic [ACC_W-1:0]        dq_r, drm_r;
  logic [DIV_CNT_W-1:0]    dcnt_r;
  logic                    dneg_r;
  logic [ACC_W:0]          dtry;

  logic [WADDR_W-1:0] waddr;
  logic [AADDR_W-1:0] aaddr;
  logic signed [ACC_W:0] asum;
  logic signed [ACC_W-1:0] asat;
  logic [ACC_W-1:0] q15;
  logic signed [ACC_W:0] qs;

  assign waddr = {p_r[PROJ_W-1:0], w_r.row};
  assign aaddr = {w_r.proj, w_r.col};
  assign idle  = (state_r == S_IDLE) && q_empty;
  assign q_pop = (state_r == S_IDLE) && !q_empty;

  assign asum = (ACC_W+1)'(ard_r) + (ACC_W+1)'(prod_r);
  assign asat = (asum > (ACC_W+1)'(ACC_MAX)) ? ACC_MAX :
                (asum < (ACC_W+1)'(ACC_MIN)) ? ACC_MIN : asum[ACC_W-1:0];
  assign dtry = {drm_r, dq_r[ACC_W-1]} - (ACC_W+1)'(w_r.rows);

  // quotient then /2^15 toward zero on magnitude, then sign and saturate
  assign q15  = dq_r >> 15;
  assign qs   = dneg_r ? -$signed({1'b0, q15}) : $signed({1'b0, q15});

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (!q_empty) begin
        unique case (q_data.cmd)
          CMD_LOAD:  state_nxt = S_IDLE;
          CMD_CLEAR: state_nxt = S_CLEAR;
          CMD_ELEM:  state_nxt = q_data.drop ? S_IDLE : S_RDW;
          CMD_READ:  state_nxt = S_RDA;
          default:   state_nxt = S_IDLE;
        endcase
      end
      S_CLEAR: if (clr_r == '1) state_nxt = S_IDLE;
      S_RDW:   state_nxt = S_MUL;
      S_MUL:   state_nxt = S_ADD;
      S_ADD:   state_nxt = (p_r + 1'b1 >= (PROJ_W+1)'(w_r.nproj)) ? S_IDLE : S_RDW;
      S_RDA:   state_nxt = rd_go_r ? S_DIV : S_RDA;
      S_DIV:   if (dcnt_r == '0) state_nxt = S_FIN;
      S_FIN:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      out_valid <= 1'b0;
      rd_go_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_valid <= (state_r == S_FIN);
      if (state_r == S_CLEAR) clr_r <= clr_r + 1'b1;
      rd_go_r <= (state_r == S_RDA);
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (q_pop && q_data.cmd == CMD_LOAD)
      wmem[{q_data.proj, q_data.row}] <= q_data.value[15:0];
    wrd_r <= wmem[waddr];
  end

  always_ff @(posedge clk) begin
    if (state_r == S_CLEAR) amem[clr_r] <= '0;
    else if (state_r == S_ADD) amem[{p_r[PROJ_W-1:0], w_r.col}] <= asat;
    ard_r <= amem[(state_r == S_RDA) ? aaddr : {p_r[PROJ_W-1:0], w_r.col}];
  end

  // datapath sequencing
  always_ff @(posedge clk) begin
    if (q_pop) begin
      w_r <= q_data;
      p_r <= '0;
    end
    if (state_r == S_MUL) prod_r <= PROD_W'(wrd_r * w_r.value);
    if (state_r == S_ADD) p_r <= p_r + 1'b1;
    if (state_r == S_RDA && rd_go_r) begin
      dneg_r <= ard_r[ACC_W-1];
      dq_r   <= ard_r[ACC_W-1] ? ACC_W'(-ard_r) : ard_r;
      drm_r  <= '0;
      dcnt_r <= DIV_CNT_W'(ACC_W - 1);
    end else if (state_r == S_DIV) begin
      if (!dtry[ACC_W]) begin
        drm_r <= dtry[ACC_W-1:0];
        dq_r  <= {dq_r[ACC_W-2:0], 1'b1};
      end else begin
        drm_r <= {drm_r[ACC_W-2:0], dq_r[ACC_W-1]};
        dq_r  <= {dq_r[ACC_W-2:0], 1'b0};
      end
      dcnt_r <= dcnt_r - 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (state_r == S_FIN) begin
      out_entry_index  <= w_r.hidx;
      out_out_of_range <= w_r.oor;
      if (w_r.oor || w_r.rows == '0) out_hash_value <= '0;
      else if (qs > 57'sd2147483647) out_hash_value <= 32'h7FFFFFFF;
      else if (qs < -57'sd2147483648) out_hash_value <= 32'h80000000;
      else out_hash_value <= qs[31:0];
    end
  end

endmodule
`default_nettype wire

### rtl/drp_checker.sv
// Port-level checks for the descriptor projection core, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module drp_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        out_valid,
  input wire logic        out_out_of_range,
  input wire logic signed [31:0] out_hash_value
);

  // an out-of-range read reports zero
  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_out_of_range |-> out_hash_value == 32'sd0)
    else $error("out-of-range read with nonzero value");

  // accepted beat makes the front busy
  a_busy_after: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy not raised after accept");

  // results never come on consecutive cycles
  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("back-to-back result strobes");

endmodule

bind descriptor_random_projection_core drp_checker u_drp_checker (
  .clk, .rst_n, .start, .busy, .out_valid, .out_out_of_range, .out_hash_value
);
`default_nettype wire
